/* hw/rtl/bcsk_pkg.sv */
`timescale 1ns / 1ps
// Package for the BCD clock setting keys block: field codes, limits,
// reset values, the time field record and the BCD helper functions. No dependencies.
package bcsk_pkg;

  localparam int ModeWidth = 3;
  localparam int ByteWidth = 8;

  localparam logic [ModeWidth-1:0] FieldNone   = 3'd0;
  localparam logic [ModeWidth-1:0] FieldHour   = 3'd1;
  localparam logic [ModeWidth-1:0] FieldMinute = 3'd2;
  localparam logic [ModeWidth-1:0] FieldSecond = 3'd3;
  localparam logic [ModeWidth-1:0] FieldDate   = 3'd4;
  localparam logic [ModeWidth-1:0] FieldMonth  = 3'd5;
  localparam logic [ModeWidth-1:0] FieldYear   = 3'd6;

  localparam logic [ByteWidth-1:0] LimitHour   = 8'h23;
  localparam logic [ByteWidth-1:0] LimitMinSec = 8'h59;
  localparam logic [ByteWidth-1:0] LimitDate   = 8'h31;
  localparam logic [ByteWidth-1:0] LimitMonth  = 8'h12;
  localparam logic [ByteWidth-1:0] LimitYear   = 8'h99;
  localparam logic [ByteWidth-1:0] FloorTime   = 8'h00;
  localparam logic [ByteWidth-1:0] FloorCal    = 8'h01;

  localparam logic [3:0] NibbleOver  = 4'ha;
  localparam logic [3:0] NibbleUnder = 4'hf;
  localparam logic [ByteWidth-1:0] NibbleFix = 8'h06;

  localparam logic [ByteWidth-1:0] ResetHour   = 8'h00;
  localparam logic [ByteWidth-1:0] ResetMinute = 8'h00;
  localparam logic [ByteWidth-1:0] ResetSecond = 8'h00;
  localparam logic [ByteWidth-1:0] ResetDate   = 8'h18;
  localparam logic [ByteWidth-1:0] ResetMonth  = 8'h04;
  localparam logic [ByteWidth-1:0] ResetYear   = 8'h23;

  typedef struct packed {
    logic [ByteWidth-1:0] hour;
    logic [ByteWidth-1:0] minute;
    logic [ByteWidth-1:0] second;
    logic [ByteWidth-1:0] date;
    logic [ByteWidth-1:0] month;
    logic [ByteWidth-1:0] year;
  } rtc_fields_t;

  typedef struct packed {
    logic mode_key;
    logic up_key;
    logic down_key;
    logic load_valid;
  } key_poll_t;

  function automatic logic [ByteWidth-1:0] bcd_fix(input logic [ByteWidth-1:0] v);
    logic [ByteWidth-1:0] a;
    a = v;
    if (a[3:0] == NibbleOver) begin
      a = a + NibbleFix;
    end
    if (a[3:0] == NibbleUnder) begin
      a = a - NibbleFix;
    end
    return a;
  endfunction

  // Up step with its correction, then down step with its correction.
  function automatic logic [ByteWidth-1:0] field_next(
    input logic [ByteWidth-1:0] v,
    input logic [ByteWidth-1:0] lim,
    input logic [ByteWidth-1:0] flr,
    input logic                 sel,
    input logic                 up,
    input logic                 dn
  );
    logic [ByteWidth-1:0] a;
    a = v;
    if (up) begin
      if (sel && (a < lim)) begin
        a = a + 8'd1;
      end
      a = bcd_fix(a);
    end
    if (dn) begin
      if (sel && (a > flr)) begin
        a = a - 8'd1;
      end
      a = bcd_fix(a);
    end
    return a;
  endfunction

endpackage

/* hw/rtl/bcsk_update.sv */
`timescale 1ns / 1ps
// Next-state logic for one key poll: load, mode advance, up and down steps.
// Depends on bcsk_pkg.
module bcsk_update (
  input  bcsk_pkg::key_poll_t             keys,
  input  bcsk_pkg::rtc_fields_t           load_fields,
  input  logic [bcsk_pkg::ModeWidth-1:0]  mode_cur,
  input  bcsk_pkg::rtc_fields_t           fields_cur,
  output logic [bcsk_pkg::ModeWidth-1:0]  mode_nxt,
  output bcsk_pkg::rtc_fields_t           fields_nxt,
  output logic                            strobe_nxt
);

  bcsk_pkg::rtc_fields_t base;
  logic [bcsk_pkg::ModeWidth-1:0] m;

  always_comb begin
    base = keys.load_valid ? load_fields : fields_cur;
    m = mode_cur;
    if (keys.mode_key) begin
      m = (m >= bcsk_pkg::FieldYear) ? bcsk_pkg::FieldNone : m + 3'd1;
    end
  end

  assign mode_nxt   = m;
  assign strobe_nxt = keys.up_key | keys.down_key;

  assign fields_nxt.hour = bcsk_pkg::field_next(base.hour, bcsk_pkg::LimitHour,
    bcsk_pkg::FloorTime, m == bcsk_pkg::FieldHour, keys.up_key, keys.down_key);
  assign fields_nxt.minute = bcsk_pkg::field_next(base.minute, bcsk_pkg::LimitMinSec,
    bcsk_pkg::FloorTime, m == bcsk_pkg::FieldMinute, keys.up_key, keys.down_key);
  assign fields_nxt.second = bcsk_pkg::field_next(base.second, bcsk_pkg::LimitMinSec,
    bcsk_pkg::FloorTime, m == bcsk_pkg::FieldSecond, keys.up_key, keys.down_key);
  assign fields_nxt.date = bcsk_pkg::field_next(base.date, bcsk_pkg::LimitDate,
    bcsk_pkg::FloorCal, m == bcsk_pkg::FieldDate, keys.up_key, keys.down_key);
  assign fields_nxt.month = bcsk_pkg::field_next(base.month, bcsk_pkg::LimitMonth,
    bcsk_pkg::FloorCal, m == bcsk_pkg::FieldMonth, keys.up_key, keys.down_key);
  assign fields_nxt.year = bcsk_pkg::field_next(base.year, bcsk_pkg::LimitYear,
    bcsk_pkg::FloorCal, m == bcsk_pkg::FieldYear, keys.up_key, keys.down_key);

endmodule

/* hw/rtl/bcd_clock_set_keys.sv */
`timescale 1ns / 1ps
// Top level of the BCD clock setting keys block: input register, state and result register.
// Depends on bcsk_pkg and bcsk_update.
//
// The block takes one key-poll word per clock cycle while in_stall is low and returns one
// result word for each. An accepted word is captured in the input register; the mode and
// time-field register, also the result register, takes its result when the output is empty
// or not stalled, so the result word is valid from then on; each word reports the field
// select, write strobe and six packed-BCD fields as they stand after that poll. A stalled
// output holds the result while one more input word is taken into the input register.
module bcd_clock_set_keys (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode_key,
  input  logic       in_up_key,
  input  logic       in_down_key,
  input  logic       in_load_valid,
  input  logic [7:0] in_load_hour,
  input  logic [7:0] in_load_minute,
  input  logic [7:0] in_load_second,
  input  logic [7:0] in_load_date,
  input  logic [7:0] in_load_month,
  input  logic [7:0] in_load_year,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_field_select,
  output logic       out_write_strobe,
  output logic [7:0] out_hour,
  output logic [7:0] out_minute,
  output logic [7:0] out_second,
  output logic [7:0] out_date,
  output logic [7:0] out_month,
  output logic [7:0] out_year
);

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  bcsk_pkg::key_poll_t   s1_keys_r;
  bcsk_pkg::rtc_fields_t s1_load_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [bcsk_pkg::ModeWidth-1:0] mode_r;
  logic [bcsk_pkg::ModeWidth-1:0] mode_nxt;
  bcsk_pkg::rtc_fields_t fields_r;
  bcsk_pkg::rtc_fields_t fields_nxt;
  logic                  strobe_r;
  logic                  strobe_nxt;
  logic                  advance;
  logic                  in_take;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  bcsk_update u_update (
    .keys        (s1_keys_r),
    .load_fields (s1_load_r),
    .mode_cur    (mode_r),
    .fields_cur  (fields_r),
    .mode_nxt    (mode_nxt),
    .fields_nxt  (fields_nxt),
    .strobe_nxt  (strobe_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_keys_r.mode_key   <= in_mode_key;
      s1_keys_r.up_key     <= in_up_key;
      s1_keys_r.down_key   <= in_down_key;
      s1_keys_r.load_valid <= in_load_valid;
      s1_load_r.hour       <= in_load_hour;
      s1_load_r.minute     <= in_load_minute;
      s1_load_r.second     <= in_load_second;
      s1_load_r.date       <= in_load_date;
      s1_load_r.month      <= in_load_month;
      s1_load_r.year       <= in_load_year;
    end
    if (advance) begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      mode_r          <= bcsk_pkg::FieldNone;
      fields_r.hour   <= bcsk_pkg::ResetHour;
      fields_r.minute <= bcsk_pkg::ResetMinute;
      fields_r.second <= bcsk_pkg::ResetSecond;
      fields_r.date   <= bcsk_pkg::ResetDate;
      fields_r.month  <= bcsk_pkg::ResetMonth;
      fields_r.year   <= bcsk_pkg::ResetYear;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        mode_r   <= mode_nxt;
        fields_r <= fields_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_field_select = mode_r;
  assign out_write_strobe = strobe_r;
  assign out_hour         = fields_r.hour;
  assign out_minute       = fields_r.minute;
  assign out_second       = fields_r.second;
  assign out_date         = fields_r.date;
  assign out_month        = fields_r.month;
  assign out_year         = fields_r.year;

endmodule

/* dv/tb_bcd_clock_set_keys.sv */
`timescale 1ns / 1ps
// Testbench for bcd_clock_set_keys: a directed table, then random key polls, checked word by
// word against the typed-in rows or a behavioral model of the setting logic. Depends on bcsk_pkg.
module tb_bcd_clock_set_keys;

  typedef struct packed {
    bcsk_pkg::key_poll_t   keys;
    bcsk_pkg::rtc_fields_t load;
  } poll_word_t;

  typedef struct packed {
    logic [2:0]            field_select;
    logic                  write_strobe;
    bcsk_pkg::rtc_fields_t fields;
  } clock_word_t;

  typedef struct packed {
    bcsk_pkg::key_poll_t   keys;
    bcsk_pkg::rtc_fields_t load;
    logic                  typed;
    logic [2:0]            sel;
    logic                  strobe;
    bcsk_pkg::rtc_fields_t res;
  } poll_row_t;

  // Columns: keys (mode, up, down, load), reading, typed-in flag, expected word.
  // Fields run hour, minute, second, date, month, year.
  localparam poll_row_t PollTable [25] = '{
    '{4'b0000, 48'h0,                 1'b1, bcsk_pkg::FieldNone,   1'b0, 48'h00_00_00_18_04_23},
    '{4'b0100, 48'h0,                 1'b1, bcsk_pkg::FieldNone,   1'b1, 48'h00_00_00_18_04_23},
    '{4'b0001, 48'hff_ff_ff_ff_ff_ff, 1'b1, bcsk_pkg::FieldNone,   1'b0, 48'hff_ff_ff_ff_ff_ff},
    '{4'b0010, 48'h0,                 1'b1, bcsk_pkg::FieldNone,   1'b1, 48'hf9_f9_f9_f9_f9_f9},
    '{4'b0101, 48'hfa_fa_fa_fa_fa_fa, 1'b1, bcsk_pkg::FieldNone,   1'b1, 48'h00_00_00_00_00_00},
    '{4'b1101, 48'h23_59_59_31_12_99, 1'b1, bcsk_pkg::FieldHour,   1'b1, 48'h23_59_59_31_12_99},
    '{4'b1100, 48'h0,                 1'b1, bcsk_pkg::FieldMinute, 1'b1, 48'h23_59_59_31_12_99},
    '{4'b1100, 48'h0,                 1'b1, bcsk_pkg::FieldSecond, 1'b1, 48'h23_59_59_31_12_99},
    '{4'b1100, 48'h0,                 1'b1, bcsk_pkg::FieldDate,   1'b1, 48'h23_59_59_31_12_99},
    '{4'b1100, 48'h0,                 1'b1, bcsk_pkg::FieldMonth,  1'b1, 48'h23_59_59_31_12_99},
    '{4'b1100, 48'h0,                 1'b1, bcsk_pkg::FieldYear,   1'b1, 48'h23_59_59_31_12_99},
    '{4'b1000, 48'h0,                 1'b1, bcsk_pkg::FieldNone,   1'b0, 48'h23_59_59_31_12_99},
    '{4'b1011, 48'h00_00_00_01_01_01, 1'b1, bcsk_pkg::FieldHour,   1'b1, 48'h00_00_00_01_01_01},
    '{4'b1010, 48'h0,                 1'b1, bcsk_pkg::FieldMinute, 1'b1, 48'h00_00_00_01_01_01},
    '{4'b1010, 48'h0,                 1'b1, bcsk_pkg::FieldSecond, 1'b1, 48'h00_00_00_01_01_01},
    '{4'b1010, 48'h0,                 1'b1, bcsk_pkg::FieldDate,   1'b1, 48'h00_00_00_01_01_01},
    '{4'b1010, 48'h0,                 1'b1, bcsk_pkg::FieldMonth,  1'b1, 48'h00_00_00_01_01_01},
    '{4'b1010, 48'h0,                 1'b1, bcsk_pkg::FieldYear,   1'b1, 48'h00_00_00_01_01_01},
    '{4'b1000, 48'h0,                 1'b1, bcsk_pkg::FieldNone,   1'b0, 48'h00_00_00_01_01_01},
    '{4'b1101, 48'h09_09_19_09_09_09, 1'b0, bcsk_pkg::FieldNone,   1'b0, 48'h0},
    '{4'b0110, 48'h0,                 1'b0, bcsk_pkg::FieldNone,   1'b0, 48'h0},
    '{4'b0011, 48'h1f_1f_1f_1f_1f_1f, 1'b0, bcsk_pkg::FieldNone,   1'b0, 48'h0},
    '{4'b1111, 48'h10_3a_4f_fa_0f_98, 1'b0, bcsk_pkg::FieldNone,   1'b0, 48'h0},
    '{4'b1011, 48'h10_10_10_10_10_10, 1'b0, bcsk_pkg::FieldNone,   1'b0, 48'h0},
    '{4'b1101, 48'h22_58_58_30_11_98, 1'b0, bcsk_pkg::FieldNone,   1'b0, 48'h0}
  };

  localparam int LongHoldCycles = 48;
  localparam int WatchdogLimit  = 2000;
  localparam int DrainCycles    = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode_key = 1'b0;
  logic       in_up_key = 1'b0;
  logic       in_down_key = 1'b0;
  logic       in_load_valid = 1'b0;
  logic [7:0] in_load_hour = '0;
  logic [7:0] in_load_minute = '0;
  logic [7:0] in_load_second = '0;
  logic [7:0] in_load_date = '0;
  logic [7:0] in_load_month = '0;
  logic [7:0] in_load_year = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_field_select;
  logic       out_write_strobe;
  logic [7:0] out_hour;
  logic [7:0] out_minute;
  logic [7:0] out_second;
  logic [7:0] out_date;
  logic [7:0] out_month;
  logic [7:0] out_year;

  logic [2:0]  model_mode;
  logic [7:0]  model_field [1:6];
  clock_word_t expected_clock_words [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  bit          idle_enable = 1'b0;
  int          holds_requested = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          rx_burst = 0;

  bcd_clock_set_keys u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode_key     (in_mode_key),
    .in_up_key       (in_up_key),
    .in_down_key     (in_down_key),
    .in_load_valid   (in_load_valid),
    .in_load_hour    (in_load_hour),
    .in_load_minute  (in_load_minute),
    .in_load_second  (in_load_second),
    .in_load_date    (in_load_date),
    .in_load_month   (in_load_month),
    .in_load_year    (in_load_year),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_select(out_field_select),
    .out_write_strobe(out_write_strobe),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second),
    .out_date        (out_date),
    .out_month       (out_month),
    .out_year        (out_year)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void settle_nibbles();
    for (int i = 1; i <= 6; i++) begin
      if (model_field[i][3:0] == bcsk_pkg::NibbleOver) begin
        model_field[i] = model_field[i] + bcsk_pkg::NibbleFix;
      end
      if (model_field[i][3:0] == bcsk_pkg::NibbleUnder) begin
        model_field[i] = model_field[i] - bcsk_pkg::NibbleFix;
      end
    end
  endfunction

  function automatic clock_word_t advance_setting_state(input poll_word_t w);
    clock_word_t r;
    logic [7:0]  ceiling;
    logic [7:0]  floor_v;
    if (w.keys.load_valid) begin
      model_field[bcsk_pkg::FieldHour]   = w.load.hour;
      model_field[bcsk_pkg::FieldMinute] = w.load.minute;
      model_field[bcsk_pkg::FieldSecond] = w.load.second;
      model_field[bcsk_pkg::FieldDate]   = w.load.date;
      model_field[bcsk_pkg::FieldMonth]  = w.load.month;
      model_field[bcsk_pkg::FieldYear]   = w.load.year;
    end
    if (w.keys.mode_key) begin
      model_mode = (model_mode == bcsk_pkg::FieldYear) ? bcsk_pkg::FieldNone
                                                       : model_mode + 3'd1;
    end
    case (model_mode)
      bcsk_pkg::FieldHour: begin
        ceiling = bcsk_pkg::LimitHour;
        floor_v = bcsk_pkg::FloorTime;
      end
      bcsk_pkg::FieldMinute, bcsk_pkg::FieldSecond: begin
        ceiling = bcsk_pkg::LimitMinSec;
        floor_v = bcsk_pkg::FloorTime;
      end
      bcsk_pkg::FieldDate: begin
        ceiling = bcsk_pkg::LimitDate;
        floor_v = bcsk_pkg::FloorCal;
      end
      bcsk_pkg::FieldMonth: begin
        ceiling = bcsk_pkg::LimitMonth;
        floor_v = bcsk_pkg::FloorCal;
      end
      default: begin
        ceiling = bcsk_pkg::LimitYear;
        floor_v = bcsk_pkg::FloorCal;
      end
    endcase
    if (w.keys.up_key) begin
      if (model_mode != bcsk_pkg::FieldNone && model_field[model_mode] < ceiling) begin
        model_field[model_mode] = model_field[model_mode] + 8'd1;
      end
      settle_nibbles();
    end
    if (w.keys.down_key) begin
      if (model_mode != bcsk_pkg::FieldNone && model_field[model_mode] > floor_v) begin
        model_field[model_mode] = model_field[model_mode] - 8'd1;
      end
      settle_nibbles();
    end
    r.field_select  = model_mode;
    r.write_strobe  = w.keys.up_key | w.keys.down_key;
    r.fields.hour   = model_field[bcsk_pkg::FieldHour];
    r.fields.minute = model_field[bcsk_pkg::FieldMinute];
    r.fields.second = model_field[bcsk_pkg::FieldSecond];
    r.fields.date   = model_field[bcsk_pkg::FieldDate];
    r.fields.month  = model_field[bcsk_pkg::FieldMonth];
    r.fields.year   = model_field[bcsk_pkg::FieldYear];
    return r;
  endfunction

  // Mostly a valid BCD reading, biased toward the ends of the range; sometimes a raw byte.
  function automatic logic [7:0] pick_load_byte(input int lo, input int hi);
    int v;
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: begin
        v = lo;
      end
      1, 2: begin
        v = hi;
      end
      default: begin
        v = $urandom_range(lo, hi);
      end
    endcase
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic poll_word_t make_random_poll();
    poll_word_t w;
    w.keys.mode_key   = ($urandom_range(0, 99) < 30);
    w.keys.up_key     = ($urandom_range(0, 99) < 45);
    w.keys.down_key   = ($urandom_range(0, 99) < 35);
    w.keys.load_valid = ($urandom_range(0, 99) < 12);
    w.load.hour       = pick_load_byte(0, 23);
    w.load.minute     = pick_load_byte(0, 59);
    w.load.second     = pick_load_byte(0, 59);
    w.load.date       = pick_load_byte(1, 31);
    w.load.month      = pick_load_byte(1, 12);
    w.load.year       = pick_load_byte(0, 99);
    return w;
  endfunction

  task automatic send_poll(input poll_word_t w, input logic typed, input clock_word_t typed_res);
    clock_word_t predicted;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode_key    <= w.keys.mode_key;
    in_up_key      <= w.keys.up_key;
    in_down_key    <= w.keys.down_key;
    in_load_valid  <= w.keys.load_valid;
    in_load_hour   <= w.load.hour;
    in_load_minute <= w.load.minute;
    in_load_second <= w.load.second;
    in_load_date   <= w.load.date;
    in_load_month  <= w.load.month;
    in_load_year   <= w.load.year;
    do @(posedge clk); while (in_stall);
    predicted = advance_setting_state(w);
    expected_clock_words.push_back(typed ? typed_res : predicted);
  endtask

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    clock_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_clock_words.size() == 0) begin
        $error("unexpected result word: field_select %h, hour %h", out_field_select, out_hour);
        mismatch_count++;
      end else begin
        e = expected_clock_words.pop_front();
        check_field("field_select", 8'(e.field_select), 8'(out_field_select));
        check_field("write_strobe", 8'(e.write_strobe), 8'(out_write_strobe));
        check_field("hour", e.fields.hour, out_hour);
        check_field("minute", e.fields.minute, out_minute);
        check_field("second", e.fields.second, out_second);
        check_field("date", e.fields.date, out_date);
        check_field("month", e.fields.month, out_month);
        check_field("year", e.fields.year, out_year);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = LongHoldCycles - 1;
      out_stall <= 1'b1;
    end else if (idle_enable && rx_burst > 0) begin
      out_stall <= 1'b1;
      rx_burst--;
    end else if (idle_enable && $urandom_range(0, 3) == 0) begin
      rx_burst = $urandom_range(1, 3) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    poll_word_t  w;
    clock_word_t typed_res;
    model_mode                         = bcsk_pkg::FieldNone;
    model_field[bcsk_pkg::FieldHour]   = bcsk_pkg::ResetHour;
    model_field[bcsk_pkg::FieldMinute] = bcsk_pkg::ResetMinute;
    model_field[bcsk_pkg::FieldSecond] = bcsk_pkg::ResetSecond;
    model_field[bcsk_pkg::FieldDate]   = bcsk_pkg::ResetDate;
    model_field[bcsk_pkg::FieldMonth]  = bcsk_pkg::ResetMonth;
    model_field[bcsk_pkg::FieldYear]   = bcsk_pkg::ResetYear;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_enable = 1'b1;

    foreach (PollTable[i]) begin
      w.keys                 = PollTable[i].keys;
      w.load                 = PollTable[i].load;
      typed_res.field_select = PollTable[i].sel;
      typed_res.write_strobe = PollTable[i].strobe;
      typed_res.fields       = PollTable[i].res;
      send_poll(w, PollTable[i].typed, typed_res);
    end

    for (int n = 0; n < 400; n++) send_poll(make_random_poll(), 1'b0, '0);

    // The receiver holds off while polls keep coming, so the block backs up.
    holds_requested++;
    for (int n = 0; n < 100; n++) send_poll(make_random_poll(), 1'b0, '0);

    in_valid <= 1'b0;
    while (expected_clock_words.size() != 0) @(posedge clk);

    for (int n = 0; n < 400; n++) send_poll(make_random_poll(), 1'b0, '0);

    idle_enable = 1'b0;
    for (int n = 0; n < 125; n++) send_poll(make_random_poll(), 1'b0, '0);
    in_valid <= 1'b0;

    while (expected_clock_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
